>>> sv/keyframe_vector_lerp_top_defines.svh
// assertion macros shared by the keyframe lerp block
`ifndef KEYFRAME_VECTOR_LERP_TOP_DEFINES_SVH
`define KEYFRAME_VECTOR_LERP_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KVL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KVL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/kvl_pkg.sv
// types and constants of the keyframe vector lerp block
package kvl_pkg;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_CLAMP     = 3'd1;
  localparam logic [2:0] STAT_ZERO_SPAN = 3'd2;
  localparam logic [2:0] STAT_LOADED    = 3'd3;
  localparam logic [2:0] STAT_REJECT    = 3'd4;

  // interpolation factor, unsigned Q1.16
  localparam logic [16:0] FACTOR_ONE  = 17'h10000;
  localparam logic [16:0] FACTOR_ZERO = 17'h00000;

  // divider runs one quotient bit per cycle
  localparam logic [4:0] DIV_LAST = 5'd16;

  // coordinate lanes for the shared multiplier
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [5:0]  key_slot;
    logic [23:0] key_time;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
    logic [23:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [2:0]  status;
  } out_item_t;

  // one stored key
  typedef struct packed {
    logic [23:0] key_time;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
  } key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEARCH,
    ST_RD_A,
    ST_RD_B,
    ST_CAP_B,
    ST_EVAL,
    ST_CHECK,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

>>> sv/kvl_ram.sv
// generic single-write, single-read ram with registered read data
module kvl_ram #(
  parameter int WIDTH = 120,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/keyframe_vector_lerp_top.sv
// keyframe table with linear interpolation of a 3-D vector
// Keyframe vector lerp. A load item (mode 0) writes one key (time and x, y, z)
// into the key table; a query item (mode 1) finds the first segment whose end
// key time is above query_time (segment 0 if none), and interpolates x, y and z
// between its two keys. Every item gives exactly one result on out_result,
// shown for one cycle with out_strobe; the receiver cannot stall it. busy is
// high from the cycle after an item is taken until its result is shown, and a
// new item may be started while the result is on the outputs. A query with
// one key skips the search; otherwise the search scans the keys in turn, one
// key per cycle through the ram read port, then the bit-serial factor divider
// runs (unless a clamp or a query at the start key time fixes the factor) and
// the shared multiplier does the three coordinates in turn. Keys must be loaded
// before a query reads them; the user must write key_count only while idle, as
// the block itself does not enforce it.
`include "keyframe_vector_lerp_top_defines.svh"

module keyframe_vector_lerp_top import kvl_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_result,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_KEYS);

  state_t             state_r, state_nxt;
  logic               strobe_r, strobe_nxt;
  logic [6:0]         key_count_r;
  in_item_t           in_r, in_nxt;
  logic [AW-1:0]      last_r, last_nxt, eff_last;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]      seg_r, seg_nxt;
  key_t               a_r, a_nxt, b_r, b_nxt;
  out_item_t          res_r, res_nxt;
  logic [23:0]        an_r, an_nxt, ad_r, ad_nxt;
  logic               q_eq_r, q_eq_nxt, q_lt_r, q_lt_nxt, t_lt_r, t_lt_nxt;
  logic [16:0]        f_r, f_nxt;
  logic [24:0]        rem_r, rem_nxt;
  logic [16:0]        quo_r, quo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [1:0]         lane_r, lane_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic signed [50:0] prod_r, prod_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  key_t               ram_wdata, ram_rdata;
  logic               slot_ok;
  logic               div_ge;
  logic [24:0]        div_rem;
  logic [31:0]        lane_a, lane_b, lane_sum;
  logic signed [50:0] prod_sh;

  // key table
  kvl_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = AW'(in_r.key_slot);
  assign ram_wdata = '{key_time: in_r.key_time, value_x: in_r.value_x,
                       value_y: in_r.value_y, value_z: in_r.value_z};
  assign slot_ok   = 32'(in_r.key_slot) < 32'(MAX_KEYS);

  // last key index in use, key_count clamped to 1..MAX_KEYS
  always_comb begin
    priority if (key_count_r == 7'd0) begin
      eff_last = '0;
    end else if (32'(key_count_r) > 32'(MAX_KEYS)) begin
      eff_last = AW'(MAX_KEYS - 1);
    end else begin
      eff_last = AW'(key_count_r - 7'd1);
    end
  end

  // restoring divider step: one quotient bit
  assign div_ge  = rem_r >= {1'b0, ad_r};
  assign div_rem = div_ge ? (rem_r - {1'b0, ad_r}) : rem_r;

  // coordinate lane select for the shared multiplier
  always_comb begin
    unique case (lane_r)
      LANE_X: begin
        lane_a = a_r.value_x;
        lane_b = b_r.value_x;
      end
      LANE_Y: begin
        lane_a = a_r.value_y;
        lane_b = b_r.value_y;
      end
      default: begin
        lane_a = a_r.value_z;
        lane_b = b_r.value_z;
      end
    endcase
  end

  // floor of f * d / 65536 added to the start coordinate
  assign prod_sh  = prod_r >>> 16;
  assign lane_sum = lane_a + prod_sh[31:0];

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    strobe_nxt    = 1'b0;
    in_nxt        = in_r;
    last_nxt      = last_r;
    addr_nxt      = addr_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    seg_nxt       = seg_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    q_eq_nxt      = q_eq_r;
    q_lt_nxt      = q_lt_r;
    t_lt_nxt      = t_lt_r;
    f_nxt         = f_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    lane_nxt      = lane_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    ram_we        = 1'b0;
    ram_raddr     = addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt   = in_item;
          last_nxt = eff_last;
          if (in_item.mode == MODE_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (eff_last == '0) begin
            seg_nxt   = '0;
            state_nxt = ST_RD_A;
          end else begin
            addr_nxt      = AW'(1);
            cmp_valid_nxt = 1'b0;
            state_nxt     = ST_SEARCH;
          end
        end
      end

      ST_LOAD: begin
        ram_we  = slot_ok;
        res_nxt = '{out_x: '0, out_y: '0, out_z: '0,
                    status: slot_ok ? STAT_LOADED : STAT_REJECT};
        state_nxt = ST_DONE;
      end

      // one key time read per cycle, compared in the cycle after its read
      ST_SEARCH: begin
        ram_raddr     = addr_r;
        addr_nxt      = addr_r + AW'(1);
        cmp_valid_nxt = 1'b1;
        cmp_idx_nxt   = addr_r;
        if (cmp_valid_r) begin
          if (in_r.query_time < ram_rdata.key_time) begin
            seg_nxt   = cmp_idx_r - AW'(1);
            state_nxt = ST_RD_A;
          end else if (cmp_idx_r == last_r) begin
            seg_nxt   = '0;
            state_nxt = ST_RD_A;
          end
        end
      end

      ST_RD_A: begin
        ram_raddr = seg_r;
        state_nxt = ST_RD_B;
      end

      ST_RD_B: begin
        ram_raddr = seg_r + AW'(1);
        a_nxt     = ram_rdata;
        state_nxt = ST_CAP_B;
      end

      ST_CAP_B: begin
        b_nxt = ram_rdata;
        if (last_r == '0) begin
          res_nxt = '{out_x: a_r.value_x, out_y: a_r.value_y,
                      out_z: a_r.value_z, status: STAT_OK};
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_EVAL;
        end
      end

      // span check, signs and magnitudes of the factor terms
      ST_EVAL: begin
        q_eq_nxt = in_r.query_time == a_r.key_time;
        q_lt_nxt = in_r.query_time < a_r.key_time;
        t_lt_nxt = b_r.key_time < a_r.key_time;
        an_nxt   = (in_r.query_time < a_r.key_time) ? (a_r.key_time - in_r.query_time)
                                                    : (in_r.query_time - a_r.key_time);
        ad_nxt   = (b_r.key_time < a_r.key_time) ? (a_r.key_time - b_r.key_time)
                                                 : (b_r.key_time - a_r.key_time);
        if (a_r.key_time == b_r.key_time) begin
          res_nxt = '{out_x: a_r.value_x, out_y: a_r.value_y,
                      out_z: a_r.value_z, status: STAT_ZERO_SPAN};
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end

      // clamp cases and a query at the start key time, else start the divider
      ST_CHECK: begin
        lane_nxt = LANE_X;
        priority if (q_eq_r) begin
          f_nxt          = FACTOR_ZERO;
          res_nxt.status = STAT_OK;
          state_nxt      = ST_DIFF;
        end else if (q_lt_r != t_lt_r) begin
          f_nxt          = FACTOR_ZERO;
          res_nxt.status = STAT_CLAMP;
          state_nxt      = ST_DIFF;
        end else if (an_r > ad_r) begin
          f_nxt          = FACTOR_ONE;
          res_nxt.status = STAT_CLAMP;
          state_nxt      = ST_DIFF;
        end else begin
          rem_nxt        = {1'b0, an_r};
          quo_nxt        = '0;
          cnt_nxt        = '0;
          res_nxt.status = STAT_OK;
          state_nxt      = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt = {div_rem[23:0], 1'b0};
        quo_nxt = {quo_r[15:0], div_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          f_nxt     = {quo_r[15:0], div_ge};
          state_nxt = ST_DIFF;
        end
      end

      ST_DIFF: begin
        d_nxt     = $signed({lane_b[31], lane_b}) - $signed({lane_a[31], lane_a});
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        prod_nxt  = $signed({1'b0, f_r}) * d_r;
        state_nxt = ST_ADD;
      end

      ST_ADD: begin
        unique case (lane_r)
          LANE_X:  res_nxt.out_x = lane_sum;
          LANE_Y:  res_nxt.out_y = lane_sum;
          default: res_nxt.out_z = lane_sum;
        endcase
        if (lane_r == LANE_Z) begin
          state_nxt = ST_DONE;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = ST_DIFF;
        end
      end

      ST_DONE: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      strobe_r    <= 1'b0;
      key_count_r <= 7'd1;
      cmp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      strobe_r    <= strobe_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    last_r    <= last_nxt;
    addr_r    <= addr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    seg_r     <= seg_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    res_r     <= res_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    q_eq_r    <= q_eq_nxt;
    q_lt_r    <= q_lt_nxt;
    t_lt_r    <= t_lt_nxt;
    f_r       <= f_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    lane_r    <= lane_nxt;
    d_r       <= d_nxt;
    prod_r    <= prod_nxt;
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = strobe_r;
  assign out_result = res_r;

  // checks
  `KVL_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item taken but block not busy")
  `KVL_ASSERT_NXT(a_strobe_once, out_strobe, !out_strobe, "result strobe held two cycles")
  `KVL_ASSERT_IMP(a_strobe_done, out_strobe, $past(state_r == ST_DONE),
                  "result strobe without finished item")
  `KVL_ASSERT_IMP(a_load_zero,
                  out_strobe && (out_result.status == STAT_LOADED ||
                                 out_result.status == STAT_REJECT),
                  out_result.out_x == '0 && out_result.out_y == '0 &&
                  out_result.out_z == '0,
                  "load result carries nonzero vector")
  `KVL_ASSERT_IMP(a_div_rem, state_r == ST_DIV, rem_r[24:1] < ad_r,
                  "divider remainder out of range")

endmodule

>>> tb/testbench.sv
// self-checking testbench for the keyframe vector lerp block
`timescale 1ns / 1ps

module testbench;
  import kvl_pkg::*;

  localparam int TABLE_KEYS  = 64;
  localparam int ITEM_TARGET = 750;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 120;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_strobe;
  out_item_t  out_result;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  // shadow of the key table and the key_count register
  key_t       key_table [TABLE_KEYS];
  logic [6:0] key_count_cfg;

  // results still owed by the block, oldest first
  out_item_t  lerp_due [$];

  int mismatches;
  int items_sent;
  int cfg_writes;
  int loads_seen;
  int ok_seen;
  int clamp_seen;
  int span_seen;
  int idle_cycles;
  bit gaps_on;

  keyframe_vector_lerp_top #(.MAX_KEYS(TABLE_KEYS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // number of keys the search really uses
  function automatic int unsigned keys_in_use();
    int unsigned n;
    n = key_count_cfg;
    if (n == 0) n = 1;
    if (n > TABLE_KEYS) n = TABLE_KEYS;
    return n;
  endfunction

  // start + floor(f * (end - start) / 2^16), exact in 64 bits
  function automatic logic [31:0] lerp_coord(logic [31:0] a, logic [31:0] b, longint f);
    longint s;
    longint d;
    longint p;
    s = longint'(signed'(a));
    d = longint'(signed'(b)) - s;
    p = f * d;
    return 32'(s + (p >>> 16));
  endfunction

  // expected result of one item; a load also updates the key table
  function automatic out_item_t predict_lerp(in_item_t it);
    out_item_t   r;
    int unsigned n;
    int unsigned seg;
    bit          found;
    logic [23:0] t1;
    logic [23:0] t2;
    longint      num;
    longint      den;
    longint      f;
    r = '0;
    // a 6-bit slot always lands inside the 64-entry table
    if (it.mode == MODE_LOAD) begin
      key_table[it.key_slot].key_time = it.key_time;
      key_table[it.key_slot].value_x  = it.value_x;
      key_table[it.key_slot].value_y  = it.value_y;
      key_table[it.key_slot].value_z  = it.value_z;
      r.status = STAT_LOADED;
      return r;
    end
    n = keys_in_use();
    if (n == 1) begin
      r.out_x  = key_table[0].value_x;
      r.out_y  = key_table[0].value_y;
      r.out_z  = key_table[0].value_z;
      r.status = STAT_OK;
      return r;
    end
    // first segment whose end key lies above the query, else segment 0
    seg = 0;
    found = 1'b0;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      if (!found && it.query_time < key_table[i + 1].key_time) begin
        seg = i;
        found = 1'b1;
      end
    end
    t1 = key_table[seg].key_time;
    t2 = key_table[seg + 1].key_time;
    if (t1 == t2) begin
      r.out_x  = key_table[seg].value_x;
      r.out_y  = key_table[seg].value_y;
      r.out_z  = key_table[seg].value_z;
      r.status = STAT_ZERO_SPAN;
      return r;
    end
    num = longint'(it.query_time) - longint'(t1);
    den = longint'(t2) - longint'(t1);
    r.status = STAT_OK;
    if (num == 0) begin
      f = 0;
    end else if ((num < 0) != (den < 0)) begin
      f = 0;
      r.status = STAT_CLAMP;
    end else begin
      if (num < 0) begin
        num = -num;
        den = -den;
      end
      if (num > den) begin
        f = 65536;
        r.status = STAT_CLAMP;
      end else begin
        f = (num * 65536) / den;
      end
    end
    r.out_x = lerp_coord(key_table[seg].value_x, key_table[seg + 1].value_x, f);
    r.out_y = lerp_coord(key_table[seg].value_y, key_table[seg + 1].value_y, f);
    r.out_z = lerp_coord(key_table[seg].value_z, key_table[seg + 1].value_z, f);
    return r;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.mode       = 1'($urandom);
    it.key_slot   = 6'($urandom);
    it.key_time   = 24'($urandom);
    it.value_x    = $urandom;
    it.value_y    = $urandom;
    it.value_z    = $urandom;
    it.query_time = 24'($urandom);
    return it;
  endfunction

  // random pause on the sending side, mostly short
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (gaps_on) begin
      if (r >= 90) n = $urandom_range(8, 40);
      else if (r >= 55) n = $urandom_range(1, 3);
    end
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // offer one item until the block takes it
  task automatic send_item(in_item_t it);
    @(negedge clk);
    in_item = it;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    lerp_due = {lerp_due, predict_lerp(it)};
    items_sent++;
    idle_gap();
  endtask

  task automatic load_key(int unsigned slot, logic [23:0] t,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = random_fields();
    it.mode     = MODE_LOAD;
    it.key_slot = 6'(slot);
    it.key_time = t;
    it.value_x  = x;
    it.value_y  = y;
    it.value_z  = z;
    send_item(it);
  endtask

  task automatic query_at(logic [23:0] q);
    in_item_t it;
    it = random_fields();
    it.mode       = MODE_QUERY;
    it.query_time = q;
    send_item(it);
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (lerp_due.size() != 0) @(posedge clk);
  endtask

  // key_count is only written with the block idle
  task automatic write_key_count(logic [6:0] v);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    key_count_cfg = v;
    cfg_writes++;
  endtask

  // load slots 0..n-1 with non-decreasing times and mostly smoothly moving values
  task automatic fill_ramp(int unsigned n);
    logic [23:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    t = 24'($urandom_range(0, 24'hFC0000));
    x = $urandom;
    y = $urandom;
    z = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      load_key(i, t, x, y, z);
      if ($urandom_range(0, 7) != 0) t = t + 24'($urandom_range(1, 2000));
      if ($urandom_range(0, 5) == 0) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else begin
        x = x + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
        y = y + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
        z = z + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      end
    end
  endtask

  // query time mostly inside the span of the keys in use
  function automatic logic [23:0] pick_query_time();
    int unsigned n;
    int unsigned r;
    logic [23:0] lo;
    logic [23:0] hi;
    logic [23:0] tmp;
    n = keys_in_use();
    lo = key_table[0].key_time;
    hi = key_table[n - 1].key_time;
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 24'($urandom_range(lo, hi));
    if (r < 75) return key_table[$urandom_range(0, n - 1)].key_time;
    return 24'($urandom);
  endfunction

  // single key in use: the query returns key 0 whatever the time
  task automatic test_single_key();
    load_key(0, 24'h000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);
    query_at(24'hFFFFFF);
    write_key_count(7'd0);
    query_at(24'h000000);
  endtask

  // segment selection, clamping, zero span and key order
  task automatic test_segment_cases();
    write_key_count(7'd2);
    load_key(1, 24'h000100, 32'h80000000, 32'h7FFFFFFF, 32'h00010000);
    query_at(24'h000080);
    query_at(24'h000000);
    query_at(24'h000100);
    query_at(24'hFFFFFF);
    // keys out of order
    load_key(0, 24'h000200, 32'h00000000, 32'hFFFFFFFF, 32'h12345678);
    query_at(24'h000080);
    query_at(24'h000180);
    query_at(24'h000300);
    // equal key times
    load_key(1, 24'h000200, 32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF);
    query_at(24'($urandom));
    // three keys, second segment reaches the top of the time range
    write_key_count(7'd3);
    load_key(2, 24'hFFFFFF, 32'hFFFF0000, 32'h00007FFF, 32'h80000001);
    load_key(0, 24'h000000, 32'h00000000, 32'h00000001, 32'hFFFFFFFE);
    load_key(1, 24'h000200, 32'h7FFF0000, 32'h80000000, 32'h00000000);
    query_at(24'h000100);
    query_at(24'h000200);
    query_at(24'hFFFFFE);
    // query before the first key
    load_key(0, 24'h000050, 32'h01234567, 32'hFEDCBA98, 32'h00000000);
    query_at(24'h000010);
  endtask

  // whole table in use, count above the table size
  task automatic test_full_table();
    write_key_count(7'd64);
    fill_ramp(TABLE_KEYS);
    write_key_count(7'd127);
    repeat (30) query_at(pick_query_time());
    query_at(24'hFFFFFF);
  endtask

  // phases of random items under changing key counts
  task automatic test_random_phases();
    in_item_t    it;
    logic [6:0]  cnt;
    int unsigned slot;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0: cnt = 7'd0;
        1: cnt = 7'd1;
        2: cnt = 7'd2;
        3: cnt = 7'd64;
        4: cnt = 7'd127;
        default: cnt = 7'($urandom_range(3, 63));
      endcase
      write_key_count(cnt);
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) fill_ramp(keys_in_use());
      repeat (40) begin
        if ($urandom_range(0, 3) == 0) begin
          // reload a key: new values, time mostly kept
          slot = $urandom_range(0, TABLE_KEYS - 1);
          it = random_fields();
          it.mode     = MODE_LOAD;
          it.key_slot = 6'(slot);
          if ($urandom_range(0, 2) != 0) it.key_time = key_table[slot].key_time;
          send_item(it);
        end else begin
          query_at(pick_query_time());
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // compare each shown result with the oldest owed one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (lerp_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_result);
        mismatches++;
      end else begin
        want = lerp_due.pop_front();
        check_field("out_x", want.out_x, out_result.out_x);
        check_field("out_y", want.out_y, out_result.out_y);
        check_field("out_z", want.out_z, out_result.out_z);
        check_field("status", 32'(want.status), 32'(out_result.status));
        case (want.status)
          STAT_LOADED:    loads_seen++;
          STAT_CLAMP:     clamp_seen++;
          STAT_ZERO_SPAN: span_seen++;
          default:        ok_seen++;
        endcase
      end
    end
  end

  // watchdog on cycles with no item taken and no result shown
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // reset, tests in turn, then the final verdict
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    key_count_cfg = 7'd1;
    for (int i = 0; i < TABLE_KEYS; i++) key_table[i] = '0;
    mismatches = 0;
    items_sent = 0;
    cfg_writes = 0;
    loads_seen = 0;
    ok_seen = 0;
    clamp_seen = 0;
    span_seen = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_key();
    test_segment_cases();
    test_full_table();
    test_random_phases();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lerp_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, lerp_due.size());
      mismatches++;
    end
    $display("sent %0d items, %0d key loads, over %0d key_count settings",
             items_sent, loads_seen, cfg_writes);
    $display("queries: %0d in range, %0d clamped, %0d on equal key times",
             ok_seen, clamp_seen, span_seen);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
